@@ rtl/byte_coded_alu_cpu_step_macros.svh @@
// Assertion macros shared by the byte-coded machine RTL.
`ifndef BYTE_CODED_ALU_CPU_STEP_MACROS_SVH
`define BYTE_CODED_ALU_CPU_STEP_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define BCACS_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define BCACS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bcacs_pkg.sv @@
// Types, codes and defaults for the byte-coded machine step block.
package bcacs_pkg;

  localparam int REG_NUM_DEF  = 8;
  localparam int REG_BITS_DEF = 32;
  localparam int PC_BITS_DEF  = 8;

  localparam logic [7:0] OP_SBN_R = 8'd15;
  localparam logic [7:0] OP_HALT  = 8'd255;

  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_BAD_OP   = 2'd1;
  localparam logic [1:0] STAT_DIV_ZERO = 2'd2;
  localparam logic [1:0] STAT_BAD_REG  = 2'd3;

  localparam int LEN_HALT  = 1;
  localparam int LEN_SHORT = 3;
  localparam int LEN_LONG  = 4;

  // Operation class, taken from opcode bits 3:1.
  typedef enum logic [2:0] {
    CL_MOV = 3'd0,
    CL_ADD = 3'd1,
    CL_SUB = 3'd2,
    CL_MUL = 3'd3,
    CL_DIV = 3'd4,
    CL_MOD = 3'd5,
    CL_CMP = 3'd6,
    CL_SBN = 3'd7
  } alu_cls_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_MUL,
    ST_DABS_L,
    ST_DABS_R,
    ST_DIV,
    ST_DFIX,
    ST_DONE
  } seq_state_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] opcode;
    logic [7:0] op_a;
    logic [7:0] op_b;
    logic [7:0] op_c;
  } in_req_t;

  typedef struct packed {
    logic [7:0]         next_pc;
    logic signed [31:0] written_value;
    logic               flag_equal;
    logic               flag_greater;
    logic               halted;
    logic [1:0]         status;
  } out_rsp_t;

endpackage

@@ rtl/byte_coded_alu_cpu_step.sv @@
// One instruction of a byte-coded register machine per request. A request is
// taken only while the block is idle; the result then sits in an output
// register while the next request may already enter. Every request passes an
// accept cycle, a register read, a decode/execute cycle and a commit cycle; mov,
// add, sub, cmp, sbn, halt, restart and all faults take no other step.
// Multiply runs a shift-add loop on the one shared adder; divide and modulo
// take magnitudes, run a restoring loop one quotient bit per cycle and fix
// the sign on the same adder. The commit cycle waits while a previous result
// is not yet taken. Registers reset to zero through per-entry valid bits, so
// restart takes no clearing pass.
`include "byte_coded_alu_cpu_step_macros.svh"

module byte_coded_alu_cpu_step #(
  parameter int REG_NUM  = bcacs_pkg::REG_NUM_DEF,
  parameter int REG_BITS = bcacs_pkg::REG_BITS_DEF,
  parameter int PC_BITS  = bcacs_pkg::PC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bcacs_pkg::in_req_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bcacs_pkg::out_rsp_t out_data
);
  import bcacs_pkg::*;

  localparam int W     = REG_BITS;
  localparam int IDX_W = (REG_NUM > 1) ? $clog2(REG_NUM) : 1;
  localparam int CNT_W = $clog2(REG_BITS);
  localparam logic [8:0]       REG_LIM  = 9'(REG_NUM);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(REG_BITS - 1);

  seq_state_t state_r, state_nxt;
  in_req_t    req_r;

  logic [W-1:0]       mem [REG_NUM];
  logic [REG_NUM-1:0] vld_r, vld_nxt;

  logic [W-1:0]       l_r, l_nxt, r_r, r_nxt, q_r, q_nxt, acc_r, acc_nxt, res_r, res_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               sl_r, sl_nxt, sr_r, sr_nxt;
  logic [1:0]         stat_r, stat_nxt;
  logic [PC_BITS-1:0] pc_r, pc_nxt;
  logic               feq_r, feq_nxt, fgt_r, fgt_nxt, halt_r, halt_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_rsp_t           out_data_r, out_data_nxt;

  // decode
  alu_cls_t   cls;
  logic       known, breg, creg, bad_reg, use1, use2;
  logic [7:0] addr1, addr2;
  logic [W-1:0] imm1, imm2;
  logic [IDX_W-1:0] idx1, idx2, idx_a;

  // shared adder
  logic [W:0]   alu_a, alu_b;
  logic         alu_sub;
  logic [W+1:0] alu_sum;
  logic         no_borrow;

  logic               mem_we;
  logic [PC_BITS-1:0] pc_adv;
  logic [W-1:0]       wv;

  always_comb begin
    cls   = alu_cls_t'(req_r.opcode[3:1]);
    known = (req_r.opcode <= OP_SBN_R);
    unique case (cls)
      CL_MOV: begin
        breg = !req_r.opcode[0];
        creg = 1'b0;
      end
      CL_CMP, CL_SBN: begin
        breg = req_r.opcode[0];
        creg = 1'b0;
      end
      default: begin
        breg = 1'b1;
        creg = req_r.opcode[0];
      end
    endcase
    bad_reg = ({1'b0, req_r.op_a} >= REG_LIM) ||
              (breg && ({1'b0, req_r.op_b} >= REG_LIM)) ||
              (creg && ({1'b0, req_r.op_c} >= REG_LIM));
    // cmp and sbn work on reg a against operand b; the rest on b against c
    if (cls == CL_CMP || cls == CL_SBN) begin
      use1  = 1'b1;
      addr1 = req_r.op_a;
      use2  = breg;
      addr2 = req_r.op_b;
    end else begin
      use1  = breg;
      addr1 = req_r.op_b;
      use2  = creg;
      addr2 = req_r.op_c;
    end
    imm1  = W'(req_r.op_b);
    imm2  = W'(addr2);
    idx1  = addr1[IDX_W-1:0];
    idx2  = addr2[IDX_W-1:0];
    idx_a = req_r.op_a[IDX_W-1:0];
  end

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    unique case (state_r)
      ST_EXEC: begin
        alu_a   = {1'b0, l_r};
        alu_b   = (cls == CL_MOV) ? '0 : {1'b0, r_r};
        alu_sub = (cls == CL_SUB) || (cls == CL_CMP) || (cls == CL_SBN);
      end
      ST_MUL: begin
        alu_a = {1'b0, acc_r};
        alu_b = r_r[0] ? {1'b0, l_r} : '0;
      end
      ST_DABS_L: begin
        alu_b   = {1'b0, l_r};
        alu_sub = l_r[W-1];
      end
      ST_DABS_R: begin
        alu_b   = {1'b0, r_r};
        alu_sub = r_r[W-1];
      end
      ST_DIV: begin
        alu_a   = {acc_r, q_r[W-1]};
        alu_b   = {1'b0, r_r};
        alu_sub = 1'b1;
      end
      ST_DFIX: begin
        alu_b   = {1'b0, (cls == CL_DIV) ? q_r : acc_r};
        alu_sub = (cls == CL_DIV) ? (sl_r ^ sr_r) : sl_r;
      end
      default: begin
        alu_sub = 1'b0;
      end
    endcase
    alu_sum   = {1'b0, alu_a} + {1'b0, alu_sub ? ~alu_b : alu_b} + (W+2)'(alu_sub);
    no_borrow = alu_sum[W+1];
  end

  always_comb begin
    state_nxt     = state_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    q_nxt         = q_r;
    acc_nxt       = acc_r;
    res_nxt       = res_r;
    cnt_nxt       = cnt_r;
    sl_nxt        = sl_r;
    sr_nxt        = sr_r;
    stat_nxt      = stat_r;
    pc_nxt        = pc_r;
    feq_nxt       = feq_r;
    fgt_nxt       = fgt_r;
    halt_nxt      = halt_r;
    vld_nxt       = vld_r;
    mem_we        = 1'b0;
    wv            = '0;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    in_ready      = (state_r == ST_IDLE);
    pc_adv        = pc_r + PC_BITS'(((cls == CL_MOV) || (cls == CL_CMP)) ? LEN_SHORT : LEN_LONG);

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = ST_READ;
      end
      ST_READ: begin
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        stat_nxt  = STAT_OK;
        state_nxt = ST_DONE;
        if (req_r.cmd || halt_r || (req_r.opcode == OP_HALT)) begin
          stat_nxt = STAT_OK;
        end else if (!known) begin
          stat_nxt = STAT_BAD_OP;
        end else if (bad_reg) begin
          stat_nxt = STAT_BAD_REG;
        end else begin
          unique case (cls)
            CL_MUL: begin
              acc_nxt   = '0;
              cnt_nxt   = '0;
              state_nxt = ST_MUL;
            end
            CL_DIV, CL_MOD: begin
              if (r_r == '0) begin
                stat_nxt = STAT_DIV_ZERO;
              end else begin
                sl_nxt    = l_r[W-1];
                sr_nxt    = r_r[W-1];
                state_nxt = ST_DABS_L;
              end
            end
            default: begin
              res_nxt = alu_sum[W-1:0];
            end
          endcase
        end
      end
      ST_MUL: begin
        acc_nxt = alu_sum[W-1:0];
        l_nxt   = l_r << 1;
        r_nxt   = r_r >> 1;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          res_nxt   = alu_sum[W-1:0];
          state_nxt = ST_DONE;
        end
      end
      ST_DABS_L: begin
        q_nxt     = alu_sum[W-1:0];
        state_nxt = ST_DABS_R;
      end
      ST_DABS_R: begin
        r_nxt     = alu_sum[W-1:0];
        acc_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        // restoring step: keep the trial difference only when it did not borrow
        acc_nxt = no_borrow ? alu_sum[W-1:0] : alu_a[W-1:0];
        q_nxt   = {q_r[W-2:0], no_borrow};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) state_nxt = ST_DFIX;
      end
      ST_DFIX: begin
        res_nxt   = alu_sum[W-1:0];
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          if (req_r.cmd) begin
            pc_nxt   = '0;
            halt_nxt = 1'b0;
            vld_nxt  = '0;
          end else if (halt_r) begin
            pc_nxt = pc_r;
          end else if (req_r.opcode == OP_HALT) begin
            halt_nxt = 1'b1;
            pc_nxt   = pc_r + PC_BITS'(LEN_HALT);
          end else if (stat_r != STAT_OK) begin
            pc_nxt = pc_r;
          end else if (cls == CL_CMP) begin
            feq_nxt = (res_r == '0);
            fgt_nxt = (res_r != '0) && !res_r[W-1];
            pc_nxt  = pc_adv;
          end else begin
            mem_we         = 1'b1;
            vld_nxt[idx_a] = 1'b1;
            wv             = res_r;
            pc_nxt         = ((cls == CL_SBN) && res_r[W-1]) ? PC_BITS'(req_r.op_c) : pc_adv;
          end
          out_data_nxt.next_pc       = 8'(pc_nxt);
          out_data_nxt.written_value = 32'(signed'(wv));
          out_data_nxt.flag_equal    = feq_nxt;
          out_data_nxt.flag_greater  = fgt_nxt;
          out_data_nxt.halted        = halt_nxt;
          out_data_nxt.status        = stat_r;
          out_valid_nxt              = 1'b1;
          state_nxt                  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pc_r        <= '0;
      feq_r       <= 1'b0;
      fgt_r       <= 1'b0;
      halt_r      <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      feq_r       <= feq_nxt;
      fgt_r       <= fgt_nxt;
      halt_r      <= halt_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) req_r <= in_data;
    q_r        <= q_nxt;
    acc_r      <= acc_nxt;
    res_r      <= res_nxt;
    cnt_r      <= cnt_nxt;
    sl_r       <= sl_nxt;
    sr_r       <= sr_nxt;
    stat_r     <= stat_nxt;
    out_data_r <= out_data_nxt;
  end

  // register file: one write port, two registered read ports used in the read cycle
  always_ff @(posedge clk) begin
    if (mem_we) mem[idx_a] <= res_r;
    if (state_r == ST_READ) begin
      l_r <= use1 ? (vld_r[idx1] ? mem[idx1] : '0) : imm1;
      r_r <= use2 ? (vld_r[idx2] ? mem[idx2] : '0) : imm2;
    end else begin
      l_r <= l_nxt;
      r_r <= r_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BCACS_ASSERT_NEXT(a_accept_reads, clk, rst_n, in_valid && in_ready,
                     state_r == ST_READ, "accepted request did not start a register read")
  `BCACS_ASSERT_SAME(a_divzero_src, clk, rst_n, state_r == ST_DONE && stat_r == STAT_DIV_ZERO,
                     cls == CL_DIV || cls == CL_MOD, "divide-by-zero status on a non-divide op")
  `BCACS_ASSERT_SAME(a_halt_no_write, clk, rst_n, out_valid && out_data.halted,
                     out_data.written_value == 32'sd0, "halted result carries a written value")

endmodule

@@ dv/tb_byte_coded_alu_cpu_step.sv @@
// Self-checking testbench for the byte-coded machine step block.
`timescale 1ns / 100ps

module tb_byte_coded_alu_cpu_step;
  import bcacs_pkg::*;

  localparam logic [7:0] OP_MOV_R = 8'd0;
  localparam logic [7:0] OP_MOV_I = 8'd1;
  localparam logic [7:0] OP_ADD_I = 8'd2;
  localparam logic [7:0] OP_ADD_R = 8'd3;
  localparam logic [7:0] OP_SUB_I = 8'd4;
  localparam logic [7:0] OP_SUB_R = 8'd5;
  localparam logic [7:0] OP_MUL_I = 8'd6;
  localparam logic [7:0] OP_MUL_R = 8'd7;
  localparam logic [7:0] OP_DIV_I = 8'd8;
  localparam logic [7:0] OP_DIV_R = 8'd9;
  localparam logic [7:0] OP_MOD_I = 8'd10;
  localparam logic [7:0] OP_MOD_R = 8'd11;
  localparam logic [7:0] OP_CMP_I = 8'd12;
  localparam logic [7:0] OP_CMP_R = 8'd13;
  localparam logic [7:0] OP_SBN_I = 8'd14;
  localparam logic [7:0] OP_UNKNOWN_LO = 8'd16;
  localparam logic [7:0] OP_UNKNOWN_HI = 8'd254;

  localparam int IDX_W        = $clog2(REG_NUM_DEF);
  localparam int RANDOM_ITEMS = 1600;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 60;
  localparam int MAX_PRINTS   = 40;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  in_req_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_rsp_t out_data;

  // Machine state as the block should hold it
  logic [31:0] m_regs [REG_NUM_DEF];
  logic [7:0]  m_pc;
  logic        m_eq;
  logic        m_gt;
  logic        m_halt;

  out_rsp_t pending_results [$];
  int       err_count = 0;
  int       cycle_count = 0;
  int       burst_left = 0;
  bit       steady_flow = 1'b0;
  int       rx_mode = 0;
  int       rx_left = 0;

  byte_coded_alu_cpu_step DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic uses_reg_b(logic [7:0] op);
    case (alu_cls_t'(op[3:1]))
      CL_MOV:         return !op[0];
      CL_CMP, CL_SBN: return op[0];
      default:        return 1'b1;
    endcase
  endfunction

  function automatic logic uses_reg_c(logic [7:0] op);
    return op[0] && (op[3:1] >= CL_ADD) && (op[3:1] <= CL_MOD);
  endfunction

  function automatic out_rsp_t make_rsp(logic [31:0] wv, logic [1:0] st);
    out_rsp_t o;
    o.next_pc       = m_pc;
    o.written_value = wv;
    o.flag_equal    = m_eq;
    o.flag_greater  = m_gt;
    o.halted        = m_halt;
    o.status        = st;
    return o;
  endfunction

  function automatic void clear_machine(bit with_flags);
    foreach (m_regs[i]) m_regs[i] = '0;
    m_pc   = '0;
    m_halt = 1'b0;
    if (with_flags) begin
      m_eq = 1'b0;
      m_gt = 1'b0;
    end
  endfunction

  // Execute one request against the machine state and return its result
  function automatic out_rsp_t run_instruction(in_req_t r);
    alu_cls_t    cls;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] res;
    logic [31:0] diff;
    logic [63:0] mx;
    logic [63:0] my;
    logic [63:0] q;
    logic        breg;
    logic        creg;
    logic [7:0]  len;
    if (r.cmd) begin
      clear_machine(1'b0);
      return make_rsp('0, STAT_OK);
    end
    if (m_halt) return make_rsp('0, STAT_OK);
    if (r.opcode == OP_HALT) begin
      m_halt = 1'b1;
      m_pc   = m_pc + 8'(LEN_HALT);
      return make_rsp('0, STAT_OK);
    end
    if (r.opcode > OP_SBN_R) return make_rsp('0, STAT_BAD_OP);
    breg = uses_reg_b(r.opcode);
    creg = uses_reg_c(r.opcode);
    if (r.op_a >= REG_NUM_DEF || (breg && r.op_b >= REG_NUM_DEF) ||
        (creg && r.op_c >= REG_NUM_DEF))
      return make_rsp('0, STAT_BAD_REG);
    cls = alu_cls_t'(r.opcode[3:1]);
    len = (cls == CL_MOV || cls == CL_CMP) ? 8'(LEN_SHORT) : 8'(LEN_LONG);
    x = breg ? m_regs[r.op_b[IDX_W-1:0]] : {24'b0, r.op_b};
    y = creg ? m_regs[r.op_c[IDX_W-1:0]] : {24'b0, r.op_c};
    case (cls)
      CL_MOV: res = x;
      CL_ADD: res = x + y;
      CL_SUB: res = x - y;
      CL_MUL: res = x * y;
      CL_DIV, CL_MOD: begin
        if (y == '0) return make_rsp('0, STAT_DIV_ZERO);
        mx = x[31] ? -{{32{x[31]}}, x} : {32'b0, x};
        my = y[31] ? -{{32{y[31]}}, y} : {32'b0, y};
        if (cls == CL_DIV) begin
          q = mx / my;
          if (x[31] ^ y[31]) q = -q;
        end else begin
          q = mx % my;
          if (x[31]) q = -q;
        end
        res = q[31:0];
      end
      CL_CMP: begin
        diff = m_regs[r.op_a[IDX_W-1:0]] - x;
        m_eq = (diff == '0);
        m_gt = (diff != '0) && !diff[31];
        m_pc = m_pc + len;
        return make_rsp('0, STAT_OK);
      end
      default: begin
        res = m_regs[r.op_a[IDX_W-1:0]] - x;
        m_regs[r.op_a[IDX_W-1:0]] = res;
        m_pc = res[31] ? r.op_c : m_pc + len;
        return make_rsp(res, STAT_OK);
      end
    endcase
    m_regs[r.op_a[IDX_W-1:0]] = res;
    m_pc = m_pc + len;
    return make_rsp(res, STAT_OK);
  endfunction

  function automatic in_req_t instr(logic [7:0] op, logic [7:0] a, logic [7:0] b,
                                    logic [7:0] c);
    in_req_t r;
    r.cmd    = 1'b0;
    r.opcode = op;
    r.op_a   = a;
    r.op_b   = b;
    r.op_c   = c;
    return r;
  endfunction

  function automatic logic [7:0] rand_imm();
    case ($urandom_range(0, 5))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return 8'd1;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic in_req_t random_instr();
    in_req_t r;
    int      pick;
    r.cmd    = 1'b0;
    r.opcode = 8'($urandom_range(0, 15));
    r.op_a   = 8'($urandom_range(0, REG_NUM_DEF - 1));
    r.op_b   = uses_reg_b(r.opcode) ? 8'($urandom_range(0, REG_NUM_DEF - 1)) : rand_imm();
    r.op_c   = uses_reg_c(r.opcode) ? 8'($urandom_range(0, REG_NUM_DEF - 1)) : rand_imm();
    pick = $urandom_range(0, 99);
    if ((m_halt && pick < 40) || pick < 2) begin
      r = in_req_t'($urandom);
      r.cmd = 1'b1;
    end else if (pick < 4) begin
      r.opcode = OP_HALT;
    end else if (pick < 8) begin
      r.opcode = 8'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI));
    end else if (pick < 14) begin
      // Any byte in any operand slot; most land out of range
      case ($urandom_range(0, 2))
        0:       r.op_a = 8'($urandom_range(0, 255));
        1:       r.op_b = 8'($urandom_range(0, 255));
        default: r.op_c = 8'($urandom_range(0, 255));
      endcase
    end
    return r;
  endfunction

  // Send one request with burst/gap pacing; valid stays high into the next burst item
  task automatic issue_request(input in_req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!steady_flow) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 50) : $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(run_instruction(r));
  endtask

  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    err_count++;
    if (err_count <= MAX_PRINTS)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
  endtask

  task automatic test_directed_cases();
    in_req_t restart;
    restart = '0;
    restart.cmd = 1'b1;
    issue_request(restart);
    issue_request(instr(OP_MOV_I, 8'd7, 8'd255, 8'd0));
    issue_request(instr(OP_MOV_R, 8'd0, 8'd7, 8'd255));
    issue_request(instr(OP_SUB_I, 8'd2, 8'd1, 8'd1));      // r2 = -1
    issue_request(instr(OP_MOV_I, 8'd3, 8'd128, 8'd0));
    issue_request(instr(OP_MUL_R, 8'd3, 8'd3, 8'd3));
    issue_request(instr(OP_MUL_R, 8'd3, 8'd3, 8'd3));
    issue_request(instr(OP_MUL_I, 8'd3, 8'd3, 8'd8));      // most negative value
    issue_request(instr(OP_DIV_R, 8'd4, 8'd3, 8'd2));      // overflowing divide
    issue_request(instr(OP_MOD_R, 8'd5, 8'd3, 8'd2));
    issue_request(instr(OP_SUB_I, 8'd6, 8'd1, 8'd7));      // r6 = -7
    issue_request(instr(OP_DIV_I, 8'd4, 8'd6, 8'd2));      // truncate toward zero
    issue_request(instr(OP_MOD_I, 8'd5, 8'd6, 8'd2));      // sign of dividend
    issue_request(instr(OP_SUB_R, 8'd1, 8'd3, 8'd2));      // one above the most negative
    issue_request(instr(OP_DIV_I, 8'd4, 8'd6, 8'd0));
    issue_request(instr(OP_MOD_R, 8'd4, 8'd6, 8'd1));      // divisor of larger magnitude
    issue_request(instr(OP_DIV_I, 8'd8, 8'd6, 8'd0));      // bad register wins over zero
    issue_request(instr(OP_ADD_R, 8'd1, 8'd255, 8'd3));
    issue_request(instr(OP_MUL_R, 8'd1, 8'd2, 8'd200));
    issue_request(instr(OP_CMP_I, 8'd7, 8'd255, 8'd0));    // equal
    issue_request(instr(OP_CMP_R, 8'd7, 8'd2, 8'd0));      // greater
    issue_request(instr(OP_CMP_I, 8'd2, 8'd0, 8'd0));      // less
    issue_request(instr(OP_SBN_I, 8'd6, 8'd1, 8'd255));    // taken
    issue_request(instr(OP_SBN_R, 8'd7, 8'd1, 8'd0));      // taken, the difference wraps negative
    issue_request(instr(OP_ADD_I, 8'd0, 8'd7, 8'd255));
    issue_request(instr(OP_UNKNOWN_LO, 8'd0, 8'd0, 8'd0));
    issue_request(instr(OP_UNKNOWN_HI, 8'd255, 8'd255, 8'd255));
    issue_request(instr(OP_HALT, 8'd0, 8'd0, 8'd0));
    issue_request(instr(OP_MOV_I, 8'd1, 8'd9, 8'd0));      // ignored while halted
    issue_request(restart);
  endtask

  task automatic test_drain_pause();
    repeat (6) issue_request(random_instr());
    wait_drained();
    repeat (6) issue_request(random_instr());
    wait_drained();
  endtask

  task automatic test_back_to_back();
    steady_flow = 1'b1;
    repeat (60) issue_request(random_instr());
    wait_drained();
    steady_flow = 1'b0;
  endtask

  task automatic test_random_programs();
    repeat (RANDOM_ITEMS) issue_request(random_instr());
    wait_drained();
  endtask

  initial begin
    clear_machine(1'b1);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    wait_drained();
    test_drain_pause();
    test_back_to_back();
    test_random_programs();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", pending_results.size(), 0);
    if (err_count == 0) begin
      $display("tb_byte_coded_alu_cpu_step: clean");
    end else begin
      $display("tb_byte_coded_alu_cpu_step: errors");
    end
    $finish;
  end

  // Receiver: switch between open, random, sparse and blocked stretches; always open in steady flow
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(5, 60);
    end else begin
      rx_left--;
    end
    if (steady_flow) begin
      out_ready <= 1'b1;
    end else begin
      case (rx_mode)
        0:       out_ready <= 1'b1;
        1:       out_ready <= 1'($urandom_range(0, 1));
        2:       out_ready <= ($urandom_range(0, 3) == 0);
        default: out_ready <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_data.written_value, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_data.next_pc !== want.next_pc)
          report_mismatch("next_pc", 32'(out_data.next_pc), 32'(want.next_pc));
        if (out_data.written_value !== want.written_value)
          report_mismatch("written_value", out_data.written_value, want.written_value);
        if (out_data.flag_equal !== want.flag_equal)
          report_mismatch("flag_equal", 32'(out_data.flag_equal), 32'(want.flag_equal));
        if (out_data.flag_greater !== want.flag_greater)
          report_mismatch("flag_greater", 32'(out_data.flag_greater),
                          32'(want.flag_greater));
        if (out_data.halted !== want.halted)
          report_mismatch("halted", 32'(out_data.halted), 32'(want.halted));
        if (out_data.status !== want.status)
          report_mismatch("status", 32'(out_data.status), 32'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_byte_coded_alu_cpu_step: errors");
      $finish;
    end
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/bcacs_pkg.sv
rtl/byte_coded_alu_cpu_step.sv
dv/tb_byte_coded_alu_cpu_step.sv
